>>> src/bicv_pkg.sv
// Shared constants, payload types and state encoding for the boot image CRC verifier.
package bicv_pkg;

  // Legacy header length in bytes and the width of the header byte counter.
  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned IDX_W = $clog2(HEADER_BYTES + 1);

  // Reflected CRC-32 constants.
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Reset value of the expected magic word.
  localparam logic [31:0] MAGIC_RESET = 32'h2705_1956;

  // Byte offsets of the big-endian header words.
  localparam logic [IDX_W-1:0] OFS_MAGIC = IDX_W'(0);
  localparam logic [IDX_W-1:0] OFS_HCRC  = IDX_W'(4);
  localparam logic [IDX_W-1:0] OFS_HEND  = IDX_W'(8);
  localparam logic [IDX_W-1:0] OFS_LEN   = IDX_W'(12);
  localparam logic [IDX_W-1:0] OFS_LEND  = IDX_W'(16);
  localparam logic [IDX_W-1:0] OFS_DCRC  = IDX_W'(24);
  localparam logic [IDX_W-1:0] OFS_DEND  = IDX_W'(28);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(HEADER_BYTES);

  // Check state, which is also the reported status code.
  typedef enum logic [1:0] {
    CHK_PENDING = 2'd0,
    CHK_BAD_IMG = 2'd1,
    CHK_CRC_ERR = 2'd2,
    CHK_OK      = 2'd3
  } check_t;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0] status;
    logic       data_done;
  } out_t;

endpackage

>>> src/bicv_crc_byte.sv
// Combinational reflected CRC-32 update over one byte.
module bicv_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  byte_in,
  output logic [31:0] crc_out
);

  // Eight bit steps of the reflected polynomial division.
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, byte_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ bicv_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> src/bicv_checker_core.sv
// Header parsing, CRC state and verdict logic, one byte per accepted transaction.
module bicv_checker_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  bicv_pkg::in_t    item,
  input  logic [31:0]      expected_magic,
  output bicv_pkg::out_t   result
);

  bicv_pkg::check_t             state_r, state_nxt;
  logic [bicv_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [31:0]                  crc_r, crc_nxt;
  logic [31:0]                  magic_r, magic_nxt;
  logic [31:0]                  hcrc_r, hcrc_nxt;
  logic [31:0]                  dcrc_r, dcrc_nxt;
  logic [31:0]                  len_r, len_nxt;
  logic                         done_r, done_nxt;

  // Current values, with restart clearing the image state ahead of this byte.
  bicv_pkg::check_t             cur_state;
  logic [bicv_pkg::IDX_W-1:0]   cur_idx;
  logic [31:0]                  cur_crc, cur_magic, cur_hcrc, cur_dcrc, cur_len;
  logic                         cur_done;
  logic [7:0]                   crc_byte;
  logic [31:0]                  crc_new;

  always_comb begin
    if (item.restart) begin
      cur_state = bicv_pkg::CHK_PENDING;
      cur_idx   = '0;
      cur_crc   = bicv_pkg::CRC_INIT;
      cur_magic = '0;
      cur_hcrc  = '0;
      cur_dcrc  = '0;
      cur_len   = '0;
      cur_done  = 1'b0;
    end else begin
      cur_state = state_r;
      cur_idx   = idx_r;
      cur_crc   = crc_r;
      cur_magic = magic_r;
      cur_hcrc  = hcrc_r;
      cur_dcrc  = dcrc_r;
      cur_len   = len_r;
      cur_done  = done_r;
    end
  end

  // The header CRC word enters the header CRC as zeros.
  assign crc_byte = (cur_state == bicv_pkg::CHK_PENDING && cur_idx >= bicv_pkg::OFS_HCRC &&
                     cur_idx < bicv_pkg::OFS_HEND) ? 8'd0 : item.data_byte;

  // One CRC network serves both the header and the data phase.
  bicv_crc_byte u_crc (
    .crc_in  (cur_crc),
    .byte_in (crc_byte),
    .crc_out (crc_new)
  );

  // Next-state logic.
  always_comb begin
    logic [31:0] len_dec;
    state_nxt = cur_state;
    idx_nxt   = cur_idx;
    crc_nxt   = cur_crc;
    magic_nxt = cur_magic;
    hcrc_nxt  = cur_hcrc;
    dcrc_nxt  = cur_dcrc;
    len_nxt   = cur_len;
    done_nxt  = cur_done;
    len_dec   = cur_len - 32'd1;
    case (cur_state)
      bicv_pkg::CHK_PENDING: begin
        // Collect the big-endian header words.
        if (cur_idx < bicv_pkg::OFS_HCRC) begin
          magic_nxt = {cur_magic[23:0], item.data_byte};
        end else if (cur_idx < bicv_pkg::OFS_HEND) begin
          hcrc_nxt = {cur_hcrc[23:0], item.data_byte};
        end else if (cur_idx >= bicv_pkg::OFS_LEN && cur_idx < bicv_pkg::OFS_LEND) begin
          len_nxt = {cur_len[23:0], item.data_byte};
        end else if (cur_idx >= bicv_pkg::OFS_DCRC && cur_idx < bicv_pkg::OFS_DEND) begin
          dcrc_nxt = {cur_dcrc[23:0], item.data_byte};
        end
        crc_nxt = crc_new;
        idx_nxt = cur_idx + 1'b1;
        // Judge the header on its last byte.
        if (idx_nxt >= bicv_pkg::IDX_LAST) begin
          if (magic_nxt != expected_magic) begin
            state_nxt = bicv_pkg::CHK_BAD_IMG;
          end else if ((crc_new ^ bicv_pkg::CRC_INIT) != hcrc_nxt) begin
            state_nxt = bicv_pkg::CHK_CRC_ERR;
          end else begin
            state_nxt = bicv_pkg::CHK_OK;
            crc_nxt   = bicv_pkg::CRC_INIT;
            // An empty payload has a data CRC of zero.
            if (len_nxt == 32'd0) begin
              done_nxt = 1'b1;
              if (dcrc_nxt != 32'd0) begin
                state_nxt = bicv_pkg::CHK_CRC_ERR;
              end
            end
          end
        end
      end
      bicv_pkg::CHK_OK: begin
        // Data phase: run the CRC until the declared length is used up.
        if (!cur_done) begin
          crc_nxt = crc_new;
          len_nxt = len_dec;
          if (len_dec == 32'd0) begin
            done_nxt = 1'b1;
            if ((crc_new ^ bicv_pkg::CRC_INIT) != cur_dcrc) begin
              state_nxt = bicv_pkg::CHK_CRC_ERR;
            end
          end
        end
      end
      default: begin
        // Final error states ignore bytes until a restart.
      end
    endcase
  end

  // Result fields reflect the state after this byte.
  always_comb begin
    result.status    = 2'(state_nxt);
    result.data_done = done_nxt;
  end

  // All state resets, including the header words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bicv_pkg::CHK_PENDING;
      idx_r   <= '0;
      crc_r   <= bicv_pkg::CRC_INIT;
      magic_r <= '0;
      hcrc_r  <= '0;
      dcrc_r  <= '0;
      len_r   <= '0;
      done_r  <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      magic_r <= magic_nxt;
      hcrc_r  <= hcrc_nxt;
      dcrc_r  <= dcrc_nxt;
      len_r   <= len_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

>>> src/boot_image_crc_verifier.sv
// Top level of the boot image header and CRC-32 verifier.
// The result of a byte is registered and presented in the cycle after its transaction.
// Throughput: one byte per cycle while the output is not stalled; the byte-wide CRC-32 network is combinational.
// A new byte enters in the same cycle that a waiting result is taken.
// Reset (synchronous, rst_n low) clears the image state and the output valid
// and restores the expected magic word to 0x27051956.
module boot_image_crc_verifier (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bicv_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bicv_pkg::out_t   out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  logic             accept;
  logic [31:0]      magic_r;
  logic             out_valid_r, out_valid_nxt;
  bicv_pkg::out_t   out_data_r;
  bicv_pkg::out_t   result;

  // Take a byte whenever the output register is free or being emptied.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Expected magic word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= bicv_pkg::MAGIC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      magic_r <= cfg_data;
    end
  end

  bicv_checker_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .item           (in_data),
    .expected_magic (magic_r),
    .result         (result)
  );

  // Output register valid tracking.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/bicv_checker.sv
// Port-level checker for the verifier, bound to the top level.
module bicv_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             out_valid,
  input  logic             out_ready,
  input  bicv_pkg::out_t   out_data
);

  // Every accepted input transaction produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after an accepted byte");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A full, stalled output register blocks the input.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output is full and stalled");

  // With no result pending, the input is always open.
  a_empty_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output register");

endmodule

bind boot_image_crc_verifier bicv_checker u_bicv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
